>>> hdl/kml_pkg.sv
// shared types and constants for the k-means lloyd block
`default_nettype none
package kml_pkg;
  // store sizes and coordinate width
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_DIM      = 8;
  localparam int COORD_BITS   = 16;

  localparam logic [1:0] CMD_LOAD_POINT    = 2'd0;
  localparam logic [1:0] CMD_LOAD_CENTROID = 2'd1;
  localparam logic [1:0] CMD_START         = 2'd2;

  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_DIMENSION    = 2'd1;
  localparam logic [1:0] REG_NUM_POINTS   = 2'd2;
  localparam logic [1:0] REG_MAX_ITER     = 2'd3;

  localparam int RESULT_LIMIT = 64;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_POINT,
    OP_LOAD_CENT,
    OP_CLEAR_ACC,   // clear sums and counts, one entry a cycle
    OP_DIST_READ,   // issue point and centroid reads
    OP_DIST_ACC,    // accumulate one squared difference term
    OP_DIST_DONE,   // compare distance against best
    OP_ACC_READ,    // read point and sum for winner
    OP_ACC_WRITE,   // write updated sum
    OP_DIV_START,   // start mean divide for one coordinate
    OP_DIV_WRITE,   // write mean into centroid store
    OP_OUT_READ,    // read centroid for output
    OP_OUT_LOAD     // load output register
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [9:0] pidx;
    logic [5:0] cidx;
    logic [2:0] didx;
    logic       first_c;
    logic       cnt_inc;
    logic       last_out;
  } kml_cmd_t;

  typedef struct packed {
    logic [5:0] best;
    logic       div_busy;
    logic       cnt_zero;
  } kml_stat_t;
endpackage
`default_nettype wire

>>> hdl/kml_div.sv
// iterative signed divider, one quotient bit a cycle, truncates toward zero
`default_nettype none
module kml_div #(
  parameter int NB = 32,
  parameter int DB = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NB-1:0] num,
  input  wire logic [DB-1:0] den,
  output logic               busy,
  output logic [NB-1:0]      quo
);
  localparam int CB = $clog2(NB + 1);
  logic [NB-1:0] q_r, q_nxt;
  logic [DB:0]   rem_r, rem_nxt;
  logic [DB-1:0] den_r;
  logic          neg_r;
  logic [CB-1:0] cnt_r;
  logic [DB:0]   trial;

  assign trial = {rem_r[DB-1:0], q_r[NB-1]};
  always_comb begin
    rem_nxt = trial;
    q_nxt   = {q_r[NB-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CB'(NB);
      neg_r <= num[NB-1];
      q_r   <= num[NB-1] ? (~num + 1'b1) : num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end
  assign busy = (cnt_r != '0);
  assign quo  = neg_r ? (~q_r + 1'b1) : q_r;
endmodule
`default_nettype wire

>>> hdl/kml_datapath.sv
// stores, distance accumulator, sum update and output register
`default_nettype none
module kml_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  kml_pkg::kml_cmd_t                   cmd,
  input  wire logic [kml_pkg::COORD_BITS-1:0] in_coord,
  output kml_pkg::kml_stat_t                  stat,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [2:0]                          out_cluster_index,
  output logic [2:0]                          out_dim_index_out,
  output logic [15:0]                         out_centroid_coord,
  output logic [10:0]                         out_cluster_size,
  output logic                                out_last
);
  import kml_pkg::*;
  localparam int PB = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CB = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DB = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NB = (MAX_POINTS > 1) ? $clog2(MAX_POINTS + 1) : 1;
  localparam int SB = COORD_BITS + NB + 1;
  localparam int QB = 2 * COORD_BITS + 2;
  localparam int XB = QB + DB + 1;

  logic [COORD_BITS-1:0] pmem [MAX_POINTS*MAX_DIM];
  logic [COORD_BITS-1:0] cmem [MAX_CLUSTERS*MAX_DIM];
  logic [SB-1:0]         smem [MAX_CLUSTERS*MAX_DIM];
  logic [NB-1:0]         cnt_r [MAX_CLUSTERS];
  logic [COORD_BITS-1:0] prd_r, crd_r;
  logic [SB-1:0]         srd_r;
  logic [XB-1:0]         dist_r;
  logic [XB-1:0]         best_d_r;
  logic [CB-1:0]         best_r;
  logic [QB-1:0]         sq_r;
  logic                  rv_r;
  logic                  sq_v_r;
  logic [COORD_BITS:0]   diff;
  logic [PB+DB-1:0]      pa;
  logic [CB+DB-1:0]      ca, ba;
  logic [SB-1:0]         quo;
  logic                  div_busy;

  assign pa = {cmd.pidx[PB-1:0], cmd.didx[DB-1:0]};
  assign ca = {cmd.cidx[CB-1:0], cmd.didx[DB-1:0]};
  assign ba = {best_r, cmd.didx[DB-1:0]};

  // point and centroid memories
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_POINT) pmem[pa] <= in_coord;
    prd_r <= pmem[pa];
  end
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_CENT) cmem[ca] <= in_coord;
    else if (cmd.op == OP_DIV_WRITE) cmem[ca] <= quo[COORD_BITS-1:0];
    crd_r <= cmem[ca];
  end
  // sum read follows the winner while accumulating, the walk index otherwise
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR_ACC) smem[ca] <= '0;
    else if (cmd.op == OP_ACC_WRITE)
      smem[ba] <= srd_r + SB'(signed'(prd_r));
    srd_r <= smem[(cmd.op == OP_ACC_READ) ? ba : ca];
  end

  // read data valid, squared difference registered, then accumulated
  assign diff = {prd_r[COORD_BITS-1], prd_r} - {crd_r[COORD_BITS-1], crd_r};
  always_ff @(posedge clk) begin
    sq_r <= QB'($signed(diff) * $signed(diff));
    if (!rst_n) begin
      rv_r   <= 1'b0;
      sq_v_r <= 1'b0;
    end else begin
      rv_r   <= (cmd.op == OP_DIST_READ || cmd.op == OP_DIST_ACC);
      sq_v_r <= rv_r;
    end
    if (cmd.op == OP_DIST_READ && cmd.didx == '0 && !sq_v_r) dist_r <= '0;
    else if (sq_v_r) dist_r <= dist_r + XB'(sq_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIST_DONE) begin
      if (cmd.first_c || dist_r < best_d_r) begin
        best_d_r <= dist_r;
        best_r   <= cmd.cidx[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt_r[i] <= '0;
    end else if (cmd.op == OP_CLEAR_ACC && cmd.didx == '0) begin
      cnt_r[cmd.cidx[CB-1:0]] <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r[best_r] <= cnt_r[best_r] + 1'b1;
    end
  end

  kml_div #(.NB(SB), .DB(NB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.op == OP_DIV_START),
    .num(srd_r), .den(cnt_r[cmd.cidx[CB-1:0]]), .busy(div_busy), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT_LOAD) begin
      out_valid          <= 1'b1;
      out_cluster_index  <= 3'(cmd.cidx);
      out_dim_index_out  <= cmd.didx;
      out_centroid_coord <= 16'(crd_r);
      out_cluster_size   <= 11'(cnt_r[cmd.cidx[CB-1:0]]);
      out_last           <= cmd.last_out;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.best     = 6'(best_r);
  assign stat.div_busy = div_busy;
  assign stat.cnt_zero = (cnt_r[cmd.cidx[CB-1:0]] == '0);
endmodule
`default_nettype wire

>>> hdl/kml_ctrl.sv
// controller sequencing loads, lloyd passes and result output
`default_nettype none
module kml_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_cmd,
  input  wire logic [9:0]   in_item_index,
  input  wire logic [2:0]   in_dim_index,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  input  kml_pkg::kml_stat_t stat,
  output kml_pkg::kml_cmd_t  cmd
);
  import kml_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_DRD = 4'd2, S_DWAIT = 4'd3,
    S_DCMP = 4'd4, S_ARD = 4'd5, S_AWR = 4'd6, S_DIVS = 4'd7, S_DIVW = 4'd8,
    S_DIVC = 4'd9, S_ORD = 4'd10, S_OLD = 4'd11, S_OWAIT = 4'd12, S_PASS = 4'd13,
    S_SRD = 4'd14;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  k_r, dim_r;
  logic [10:0] np_r;
  logic [15:0] iter_max_r, iter_r;
  logic [9:0]  p_r;
  logic [5:0]  c_r;
  logic [2:0]  d_r;
  logic [6:0]  n_r;
  logic [1:0]  w_r;
  logic [3:0]  k_eff, dim_eff;
  logic [10:0] np_eff;
  logic [6:0]  total;
  logic        acc;

  assign k_eff   = (k_r == 0) ? 4'd1 : (k_r > 4'(MAX_CLUSTERS)) ? 4'(MAX_CLUSTERS) : k_r;
  assign dim_eff = (dim_r == 0) ? 4'd1 : (dim_r > 4'(MAX_DIM)) ? 4'(MAX_DIM) : dim_r;
  assign np_eff  = (np_r == 0) ? 11'd1 : (np_r > 11'(MAX_POINTS)) ? 11'(MAX_POINTS) : np_r;
  assign total   = ({3'd0, k_eff} * {3'd0, dim_eff} > 7'(RESULT_LIMIT))
                   ? 7'(RESULT_LIMIT) : 7'({3'd0, k_eff} * {3'd0, dim_eff});

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign acc = in_valid && in_ready;

  wire d_end = ({1'b0, d_r} + 4'd1 == dim_eff);
  wire c_end = ({2'b0, c_r} + 8'd1 == {4'd0, k_eff});
  wire p_end = ({1'b0, p_r} + 11'd1 == np_eff);

  always_comb begin
    cmd = '0;
    cmd.pidx = p_r;
    cmd.cidx = c_r;
    cmd.didx = d_r;
    cmd.first_c = (c_r == 0);
    cmd.last_out = (n_r + 7'd1 == total);
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.pidx = in_item_index;
        cmd.cidx = 6'(in_item_index);
        cmd.didx = in_dim_index;
        if (acc) begin
          if (in_cmd == CMD_LOAD_POINT && 32'(in_item_index) < MAX_POINTS &&
              32'(in_dim_index) < MAX_DIM)
            cmd.op = OP_LOAD_POINT;
          else if (in_cmd == CMD_LOAD_CENTROID && 32'(in_item_index) < MAX_CLUSTERS &&
                   32'(in_dim_index) < MAX_DIM)
            cmd.op = OP_LOAD_CENT;
          else if (in_cmd == CMD_START)
            state_nxt = (iter_max_r == 0) ? S_ORD : S_CLR;
        end
      end
      S_CLR:   begin cmd.op = OP_CLEAR_ACC; cmd.didx = d_r; end
      S_DRD:   cmd.op = d_r == '0 ? OP_DIST_READ : OP_DIST_ACC;
      S_DWAIT: cmd.op = OP_NONE;
      S_DCMP:  cmd.op = OP_DIST_DONE;
      S_ARD:   begin cmd.op = OP_ACC_READ; cmd.cnt_inc = (d_r == '0); end
      S_AWR:   cmd.op = OP_ACC_WRITE;
      S_SRD:   cmd.op = OP_NONE;
      S_DIVS:  cmd.op = stat.cnt_zero ? OP_NONE : OP_DIV_START;
      S_DIVW:  cmd.op = OP_NONE;
      S_DIVC:  cmd.op = OP_DIV_WRITE;
      S_ORD:   cmd.op = OP_OUT_READ;
      S_OLD:   cmd.op = OP_OUT_LOAD;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= 4'd1; dim_r <= 4'd2; np_r <= 11'd1; iter_max_r <= 16'd10;
      p_r <= '0; c_r <= '0; d_r <= '0; n_r <= '0; iter_r <= '0; w_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
              REG_NUM_CLUSTERS: k_r <= cfg_data[3:0];
              REG_DIMENSION:    dim_r <= cfg_data[3:0];
              REG_NUM_POINTS:   np_r <= cfg_data[10:0];
              default:          iter_max_r <= cfg_data;
            endcase
          end
          if (acc && in_cmd == CMD_START) begin
            p_r <= '0; c_r <= '0; d_r <= '0; n_r <= '0; iter_r <= '0;
            state_r <= (iter_max_r == 0) ? S_ORD : S_CLR;
          end
        end
        S_CLR: begin
          if (d_r == 3'(MAX_DIM - 1)) begin
            d_r <= '0;
            if (c_r == 6'(MAX_CLUSTERS - 1)) begin c_r <= '0; state_r <= S_DRD; end
            else c_r <= c_r + 1'b1;
          end else d_r <= d_r + 1'b1;
        end
        S_DRD: begin
          if (d_end) begin d_r <= '0; w_r <= '0; state_r <= S_DWAIT; end
          else d_r <= d_r + 1'b1;
        end
        S_DWAIT: begin
          w_r <= w_r + 1'b1;
          if (w_r == 2'd2) state_r <= S_DCMP;
        end
        S_DCMP: begin
          if (c_end) begin c_r <= '0; state_r <= S_ARD; end
          else begin c_r <= c_r + 1'b1; state_r <= S_DRD; end
        end
        S_ARD: state_r <= S_AWR;
        S_AWR: begin
          if (d_end) begin
            d_r <= '0;
            if (p_end) begin p_r <= '0; state_r <= S_SRD; end
            else begin p_r <= p_r + 1'b1; state_r <= S_DRD; end
          end else begin d_r <= d_r + 1'b1; state_r <= S_ARD; end
        end
        S_SRD: state_r <= S_DIVS;
        S_DIVS: state_r <= stat.cnt_zero ? S_PASS : S_DIVW;
        S_DIVW: if (!stat.div_busy) state_r <= S_DIVC;
        S_DIVC: state_r <= S_PASS;
        S_PASS: begin
          if (d_end) begin
            d_r <= '0;
            if (c_end) begin
              c_r <= '0;
              if (iter_r + 16'd1 == iter_max_r) state_r <= S_ORD;
              else begin iter_r <= iter_r + 1'b1; state_r <= S_CLR; end
            end else begin c_r <= c_r + 1'b1; state_r <= S_SRD; end
          end else begin d_r <= d_r + 1'b1; state_r <= S_SRD; end
        end
        S_ORD: state_r <= S_OLD;
        S_OLD: state_r <= S_OWAIT;
        S_OWAIT: begin
          if (!out_valid || out_ready) begin
            n_r <= n_r + 1'b1;
            if (n_r + 7'd1 == total) state_r <= S_IDLE;
            else begin
              state_r <= S_ORD;
              if (d_end) begin d_r <= '0; c_r <= c_r + 1'b1; end
              else d_r <= d_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/kmeans_lloyd_iteration.sv
// top level of the k-means lloyd iteration engine
// usage:
//  - in_ channel takes requests: cmd 0 loads one point coordinate, cmd 1 one
//    initial centroid coordinate, each by item and dim index; cmd 2 starts a run
//  - load requests are accepted back to back
//  - a start request runs max_iterations passes; each pass clears every sum
//    entry, then for each point walks the distance to every cluster and
//    updates the winner's sums, then divides each coordinate of a non-empty
//    cluster in the serial divider; an empty cluster keeps its centroid
//  - results come out on out_ as one request per centroid coordinate, with
//    the cluster size; out_last marks the final one; the engine holds the
//    result and waits while the receiver stalls
//  - cfg_ writes registers only while idle; in_ready and cfg_ready are low
//    from the start request until the last result is taken
//  - synchronous reset restores register defaults and empties the output
//    register; point and centroid memories hold junk until written
`default_nettype none
module kmeans_lloyd_iteration (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [9:0]  in_item_index,
  input  wire logic [2:0]  in_dim_index,
  input  wire logic [15:0] in_coord,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_cluster_index,
  output logic [2:0]       out_dim_index_out,
  output logic [15:0]      out_centroid_coord,
  output logic [10:0]      out_cluster_size,
  output logic             out_last
);
  import kml_pkg::*;
  kml_cmd_t  cmd;
  kml_stat_t stat;

  // sequencer
  kml_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_item_index(in_item_index), .in_dim_index(in_dim_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  // memories and arithmetic
  kml_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_coord(in_coord),
    .stat(stat), .out_ready(out_ready), .out_valid(out_valid),
    .out_cluster_index(out_cluster_index), .out_dim_index_out(out_dim_index_out),
    .out_centroid_coord(out_centroid_coord), .out_cluster_size(out_cluster_size),
    .out_last(out_last)
  );
endmodule
`default_nettype wire

>>> hdl/kml_checker.sv
// port-level checker for the k-means engine, bound to the top level
`default_nettype none
module kml_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic cfg_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("request withdrawn");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_cfg_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == in_ready) else $error("cfg and input readiness differ");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid) else $error("result after last");
endmodule
bind kmeans_lloyd_iteration kml_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .cfg_ready(cfg_ready), .out_valid(out_valid), .out_ready(out_ready),
  .out_last(out_last)
);
`default_nettype wire
